// ----- rtl/llte_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the linked list table engine.
// No dependencies; every other file of the block but llte_ram refers to it by scoped names.
package llte_pkg;

    localparam int KEY_W   = 32;
    localparam int OP_W    = 3;
    localparam int COUNT_W = 7;

    typedef enum logic [OP_W-1:0] {
        OP_INS_SORTED = 3'd0,
        OP_INS_HEAD   = 3'd1,
        OP_INS_TAIL   = 3'd2,
        OP_RM_HEAD    = 3'd3,
        OP_RM_TAIL    = 3'd4,
        OP_RM_KEY     = 3'd5,
        OP_SEARCH     = 3'd6,
        OP_CLEAR      = 3'd7
    } t_op;

    // which index drives the read port of both entry memories
    typedef enum logic [1:0] {
        RD_HEAD = 2'd0,
        RD_FREE = 2'd1,
        RD_LINK = 2'd2
    } t_rd_sel;

    typedef struct packed {
        t_rd_sel rd_sel;
        logic    load_req;    // latch the request key
        logic    clear;       // relink the pool as after reset
        logic    walk_init;   // latch next free entry, cur = head, prev = none
        logic    advance;     // prev = cur, cur = link of cur
        logic    tail_end;    // prev = cur, cur = none
        logic    succ_load;   // latch link of cur as successor
        logic    ins_entry;   // write key and link of the new entry
        logic    ins_link;    // hook new entry after prev, pop the free list
        logic    unlink;      // hook successor after prev
        logic    release_cur; // push cur onto the free list
        logic    res_load;    // capture the result item
        logic    res_ok;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic cur_valid;
        logic link_valid;
        logic key_less;
        logic key_eq;
    } t_status;

endpackage

// ----- rtl/llte_req_if.sv -----
`timescale 1ns / 1ps
// Request channel of the linked list table engine: valid/ready plus op and key.
// Depends on llte_pkg.
interface llte_req_if;
    logic                                valid;
    logic                                ready;
    logic [llte_pkg::OP_W-1:0]           op;
    logic signed [llte_pkg::KEY_W-1:0]   key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

// ----- rtl/llte_rsp_if.sv -----
`timescale 1ns / 1ps
// Result channel of the linked list table engine: valid/ready plus status fields.
// Depends on llte_pkg.
interface llte_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [llte_pkg::COUNT_W-1:0]  count;
    logic                          empty_res;
    logic                          full_res;

    modport source (output valid, output ok, output count, output empty_res,
                    output full_res, input ready);
    modport sink   (input valid, input ok, input count, input empty_res,
                    input full_res, output ready);
endinterface

// ----- rtl/llte_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module llte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [$clog2(DEPTH)-1:0]          i_waddr,
    input  logic [WIDTH-1:0]                  i_wdata,
    input  logic [$clog2(DEPTH)-1:0]          i_raddr,
    output logic [WIDTH-1:0]                  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/llte_dpath.sv -----
`timescale 1ns / 1ps
// Datapath of the linked list table engine: key and link memories, list and
// free list pointers, walk registers and result register. Depends on llte_pkg, llte_ram.
module llte_dpath #(
    parameter int POOL_DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [llte_pkg::KEY_W-1:0]   i_key,
    input  llte_pkg::t_cmd                      i_cmd,
    output llte_pkg::t_status                   o_status,
    output logic                                o_ok,
    output logic [llte_pkg::COUNT_W-1:0]        o_count,
    output logic                                o_empty_res,
    output logic                                o_full_res
);

    localparam int AW    = $clog2(POOL_DEPTH);
    localparam int IW    = $clog2(POOL_DEPTH + 1);
    localparam int CNT_W = (IW > llte_pkg::COUNT_W) ? IW : llte_pkg::COUNT_W;
    localparam logic [IW-1:0] NONE = IW'(POOL_DEPTH);

    logic signed [llte_pkg::KEY_W-1:0] r_key, n_key;
    logic [IW-1:0]    r_head, n_head;
    logic [IW-1:0]    r_free, n_free;
    logic [IW-1:0]    r_fill, n_fill;    // entries at or above this were never used
    logic [CNT_W-1:0] r_count, n_count;
    logic [IW-1:0]    r_cur, n_cur;
    logic [IW-1:0]    r_prev, n_prev;
    logic [IW-1:0]    r_succ, n_succ;
    logic [IW-1:0]    r_nfree, n_nfree;
    logic             r_res_ok, n_res_ok;
    logic [llte_pkg::COUNT_W-1:0] r_res_count, n_res_count;
    logic             r_res_empty, n_res_empty;
    logic             r_res_full, n_res_full;

    logic signed [llte_pkg::KEY_W-1:0] rd_key;
    logic [IW-1:0]    rd_link;
    logic [IW-1:0]    rd_idx;
    logic             link_we;
    logic [IW-1:0]    link_widx;
    logic [IW-1:0]    link_wdata;
    logic             prev_valid;
    logic             fresh;

    assign prev_valid = (r_prev < NONE);
    assign fresh      = (r_free >= r_fill);

    always_comb begin
        case (i_cmd.rd_sel)
            llte_pkg::RD_FREE: rd_idx = r_free;
            llte_pkg::RD_LINK: rd_idx = rd_link;
            default:           rd_idx = r_head;
        endcase
    end

    always_comb begin
        link_we    = 1'b0;
        link_widx  = r_free;
        link_wdata = r_cur;
        if (i_cmd.ins_entry) begin
            link_we = 1'b1;
        end else if (i_cmd.ins_link) begin
            link_we    = prev_valid;
            link_widx  = r_prev;
            link_wdata = r_free;
        end else if (i_cmd.unlink) begin
            link_we    = prev_valid;
            link_widx  = r_prev;
            link_wdata = r_succ;
        end else if (i_cmd.release_cur) begin
            link_we    = 1'b1;
            link_widx  = r_cur;
            link_wdata = r_free;
        end
    end

    llte_ram #(
        .WIDTH (llte_pkg::KEY_W),
        .DEPTH (POOL_DEPTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ins_entry),
        .i_waddr (r_free[AW-1:0]),
        .i_wdata (r_key),
        .i_raddr (rd_idx[AW-1:0]),
        .o_rdata (rd_key)
    );

    llte_ram #(
        .WIDTH (IW),
        .DEPTH (POOL_DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_widx[AW-1:0]),
        .i_wdata (link_wdata),
        .i_raddr (rd_idx[AW-1:0]),
        .o_rdata (rd_link)
    );

    always_comb begin
        n_key       = r_key;
        n_head      = r_head;
        n_free      = r_free;
        n_fill      = r_fill;
        n_count     = r_count;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_succ      = r_succ;
        n_nfree     = r_nfree;
        n_res_ok    = r_res_ok;
        n_res_count = r_res_count;
        n_res_empty = r_res_empty;
        n_res_full  = r_res_full;

        if (i_cmd.load_req) begin
            n_key = i_key;
        end
        if (i_cmd.clear) begin
            n_head  = NONE;
            n_free  = '0;
            n_fill  = '0;
            n_count = '0;
        end
        if (i_cmd.walk_init) begin
            // never-used entries chain to the next index without a stored link
            n_nfree = fresh ? (r_free + IW'(1)) : rd_link;
            n_cur   = r_head;
            n_prev  = NONE;
        end
        if (i_cmd.advance) begin
            n_prev = r_cur;
            n_cur  = rd_link;
        end
        if (i_cmd.tail_end) begin
            n_prev = r_cur;
            n_cur  = NONE;
        end
        if (i_cmd.succ_load) begin
            n_succ = rd_link;
        end
        if (i_cmd.ins_link) begin
            if (!prev_valid) begin
                n_head = r_free;
            end
            n_free  = r_nfree;
            n_count = r_count + CNT_W'(1);
            if (fresh) begin
                n_fill = r_fill + IW'(1);
            end
        end
        if (i_cmd.unlink && !prev_valid) begin
            n_head = r_succ;
        end
        if (i_cmd.release_cur) begin
            n_free  = r_cur;
            n_count = r_count - CNT_W'(1);
        end
        if (i_cmd.res_load) begin
            n_res_ok    = i_cmd.res_ok;
            n_res_count = r_count[llte_pkg::COUNT_W-1:0];
            n_res_empty = (r_head == NONE);
            n_res_full  = (r_free == NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= NONE;
            r_free  <= '0;
            r_fill  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_free  <= n_free;
            r_fill  <= n_fill;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_cur       <= n_cur;
        r_prev      <= n_prev;
        r_succ      <= n_succ;
        r_nfree     <= n_nfree;
        r_res_ok    <= n_res_ok;
        r_res_count <= n_res_count;
        r_res_empty <= n_res_empty;
        r_res_full  <= n_res_full;
    end

    assign o_status.empty      = (r_head == NONE);
    assign o_status.full       = (r_free == NONE);
    assign o_status.cur_valid  = (r_cur < NONE);
    assign o_status.link_valid = (rd_link < NONE);
    assign o_status.key_less   = (rd_key < r_key);
    assign o_status.key_eq     = (rd_key == r_key);

    assign o_ok        = r_res_ok;
    assign o_count     = r_res_count;
    assign o_empty_res = r_res_empty;
    assign o_full_res  = r_res_full;

endmodule

// ----- rtl/llte_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the linked list table engine: sequences one request through
// check, link walk, memory updates and result hand-off. Depends on llte_pkg.
module llte_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic [llte_pkg::OP_W-1:0]     i_req_op,
    output logic                          o_req_ready,
    input  logic                          i_rsp_ready,
    output logic                          o_rsp_valid,
    output llte_pkg::t_cmd                o_cmd,
    input  llte_pkg::t_status             i_status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_FREE_RD,
        S_SCAN,
        S_INS_ENTRY,
        S_INS_LINK,
        S_UNLINK,
        S_RELEASE,
        S_FINISH
    } t_state;

    t_state          r_state, n_state;
    llte_pkg::t_op   r_op, n_op;
    logic            r_ok, n_ok;
    logic            r_rsp_valid, n_rsp_valid;
    llte_pkg::t_cmd  cmd;
    logic            slot_free;
    logic            is_insert;

    assign slot_free = !r_rsp_valid || i_rsp_ready;
    assign is_insert = r_op inside {llte_pkg::OP_INS_SORTED, llte_pkg::OP_INS_HEAD,
                                    llte_pkg::OP_INS_TAIL};

    always_comb begin
        cmd        = '0;
        cmd.rd_sel = llte_pkg::RD_HEAD;
        n_state    = r_state;
        n_op       = r_op;
        n_ok       = r_ok;

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    cmd.load_req = 1'b1;
                    n_op         = llte_pkg::t_op'(i_req_op);
                    n_state      = S_START;
                end
            end
            S_START: begin
                if (r_op == llte_pkg::OP_CLEAR) begin
                    cmd.clear = 1'b1;
                    n_ok      = 1'b1;
                    n_state   = S_FINISH;
                end else if (is_insert ? i_status.full : i_status.empty) begin
                    n_ok    = 1'b0;
                    n_state = S_FINISH;
                end else begin
                    cmd.rd_sel = llte_pkg::RD_FREE;
                    n_state    = S_FREE_RD;
                end
            end
            S_FREE_RD: begin
                cmd.walk_init = 1'b1;
                cmd.rd_sel    = llte_pkg::RD_HEAD;
                n_state       = S_SCAN;
            end
            S_SCAN: begin
                cmd.rd_sel = llte_pkg::RD_LINK;
                case (r_op)
                    llte_pkg::OP_INS_SORTED: begin
                        if (i_status.cur_valid && i_status.key_less) begin
                            cmd.advance = 1'b1;
                        end else begin
                            n_state = S_INS_ENTRY;
                        end
                    end
                    llte_pkg::OP_INS_HEAD: begin
                        n_state = S_INS_ENTRY;
                    end
                    llte_pkg::OP_INS_TAIL: begin
                        if (!i_status.cur_valid) begin
                            n_state = S_INS_ENTRY;
                        end else if (i_status.link_valid) begin
                            cmd.advance = 1'b1;
                        end else begin
                            cmd.tail_end = 1'b1;
                            n_state      = S_INS_ENTRY;
                        end
                    end
                    llte_pkg::OP_RM_HEAD: begin
                        cmd.succ_load = 1'b1;
                        n_state       = S_UNLINK;
                    end
                    llte_pkg::OP_RM_TAIL: begin
                        if (i_status.link_valid) begin
                            cmd.advance = 1'b1;
                        end else begin
                            cmd.succ_load = 1'b1;
                            n_state       = S_UNLINK;
                        end
                    end
                    llte_pkg::OP_RM_KEY: begin
                        if (!i_status.cur_valid) begin
                            n_ok    = 1'b0;
                            n_state = S_FINISH;
                        end else if (i_status.key_eq) begin
                            cmd.succ_load = 1'b1;
                            n_state       = S_UNLINK;
                        end else begin
                            cmd.advance = 1'b1;
                        end
                    end
                    llte_pkg::OP_SEARCH: begin
                        if (!i_status.cur_valid) begin
                            n_ok    = 1'b0;
                            n_state = S_FINISH;
                        end else if (i_status.key_eq) begin
                            n_ok    = 1'b1;
                            n_state = S_FINISH;
                        end else begin
                            cmd.advance = 1'b1;
                        end
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_INS_ENTRY: begin
                cmd.ins_entry = 1'b1;
                n_state       = S_INS_LINK;
            end
            S_INS_LINK: begin
                cmd.ins_link = 1'b1;
                n_ok         = 1'b1;
                n_state      = S_FINISH;
            end
            S_UNLINK: begin
                cmd.unlink = 1'b1;
                n_state    = S_RELEASE;
            end
            S_RELEASE: begin
                cmd.release_cur = 1'b1;
                n_ok            = 1'b1;
                n_state         = S_FINISH;
            end
            S_FINISH: begin
                // hold until the output register is free
                if (slot_free) begin
                    cmd.res_load = 1'b1;
                    cmd.res_ok   = r_ok;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_rsp_valid = cmd.res_load ? 1'b1 : (r_rsp_valid && !i_rsp_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= llte_pkg::OP_CLEAR;
            r_ok        <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_ok        <= n_ok;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_cmd       = cmd;

endmodule

// ----- rtl/linked_list_table_engine.sv -----
`timescale 1ns / 1ps
// Top level of the linked list table engine: controller, datapath and checks.
// Depends on llte_pkg, llte_req_if, llte_rsp_if, llte_ctrl, llte_dpath.

// A pool of POOL_DEPTH entries holds one singly linked list of signed 32-bit
// keys; unused entries sit on a free list. Each request item carries an op
// (sorted insert, head insert, tail insert, remove head, remove tail, remove
// key, search, clear) and a key, and yields one result item: ok, the entry
// count, and the empty and full marks after the operation. Requests are
// handled one at a time. A clear, or a request refused at once (full pool on
// insert, empty list on remove or search), goes straight to the result; any
// other request reads the free list head, walks the list and, for an insert
// or a remove that hits, updates the memories. The walk reads the key and
// link memories once per entry it passes over. Head insert and head remove
// do not walk. The next request is taken while a result waits in the output
// register. Clear and reset touch only the pointers: entries never used since
// then are tracked by a fill mark, so the memories need no clearing pass.
// Stored keys survive a clear but are never read before being written again.
module linked_list_table_engine #(
    parameter int POOL_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    llte_req_if.sink          i_req,
    llte_rsp_if.source        o_rsp
);

    llte_pkg::t_cmd     cmd;
    llte_pkg::t_status  status;
    logic               req_ready;
    logic               rsp_valid;
    logic               rsp_ok;
    logic [llte_pkg::COUNT_W-1:0] rsp_count;
    logic               rsp_empty;
    logic               rsp_full;

    // sequencing: one request through check, walk, update and hand-off
    llte_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_op    (i_req.op),
        .o_req_ready (req_ready),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (rsp_valid),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // memories, pointers and the result register
    llte_dpath #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (i_req.key),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_ok        (rsp_ok),
        .o_count     (rsp_count),
        .o_empty_res (rsp_empty),
        .o_full_res  (rsp_full)
    );

    assign i_req.ready     = req_ready;
    assign o_rsp.valid     = rsp_valid;
    assign o_rsp.ok        = rsp_ok;
    assign o_rsp.count     = rsp_count;
    assign o_rsp.empty_res = rsp_empty;
    assign o_rsp.full_res  = rsp_full;

`ifndef SYNTHESIS
    // one item at a time: an accepted request closes the input until done
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while another is in progress");

    // a pool of two or more entries is never empty and full at once
    a_not_empty_and_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.empty_res && o_rsp.full_res))
        else $error("result reports both empty and full");

    // empty mark agrees with the count where the count field holds it whole
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> ((POOL_DEPTH >= 128) || (o_rsp.empty_res == (o_rsp.count == '0))))
        else $error("empty mark disagrees with entry count");

    // full mark means every entry of the pool is on the list
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.full_res) |->
            ((POOL_DEPTH >= 128) ||
             (o_rsp.count == llte_pkg::COUNT_W'(POOL_DEPTH))))
        else $error("full mark disagrees with entry count");
`endif

endmodule

// ----- test/tb_linked_list_table_engine.sv -----
`timescale 1ns / 1ps
// Self-checking bench for linked_list_table_engine: driver, monitor, list predictor.
// Depends on llte_pkg, llte_req_if, llte_rsp_if and the engine top level.
module tb_linked_list_table_engine;

    localparam int COUNT_W = llte_pkg::COUNT_W;
    localparam int KEY_W   = llte_pkg::KEY_W;
    localparam int POOL = 64;
    localparam int N_ITEMS = 950;
    localparam logic [COUNT_W-1:0] NO_ENTRY = COUNT_W'(POOL);
    // leave room for the slowest walk after the last result
    localparam int SETTLE_CYCLES = 2 * POOL + 16;

    // one request item as the driver presents it
    typedef struct {
        llte_pkg::t_op            op;
        logic signed [KEY_W-1:0]  key;
        int                       gap;    // idle cycles before presenting
        bit                       drain;  // hold until every result is back
    } t_req_item;

    // one result item: what the engine reports after each request
    typedef struct packed {
        logic               ok;
        logic [COUNT_W-1:0] count;
        logic               empty_res;
        logic               full_res;
    } t_list_status;

    logic i_clk;
    logic i_rst_n;

    llte_req_if req_bus ();
    llte_rsp_if rsp_bus ();

    linked_list_table_engine #(
        .POOL_DEPTH (POOL)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the pool: keys, links, list head, free head, count.
    // An index equal to POOL means "no entry".
    // ------------------------------------------------------------------
    logic signed [KEY_W-1:0] shadow_key  [POOL];
    logic [COUNT_W-1:0]      shadow_link [POOL];
    logic [COUNT_W-1:0]      shadow_head;
    logic [COUNT_W-1:0]      shadow_free;
    logic [COUNT_W-1:0]      shadow_count;

    t_req_item      pending_reqs [$];
    t_list_status   expected_status [$];

    int n_built;
    int n_accepted;
    int n_checked;
    int n_errors;
    int n_refused;
    int n_full_seen;
    int n_empty_seen;
    int tx_calm;
    int rx_calm;

    logic signed [KEY_W-1:0] key_pool [16];

    // driver and monitor working state
    t_req_item tx_cur;
    bit        tx_holding;
    bit        tx_presenting;
    int        tx_wait;
    int        rx_wait;

    // ------------------------------------------------------------------
    // Pool predictor
    // ------------------------------------------------------------------
    function automatic bit is_entry(logic [COUNT_W-1:0] idx);
        return idx < NO_ENTRY;
    endfunction

    // Rebuild the free chain as after reset; stored keys stay untouched.
    function automatic void relink_shadow();
        for (int i = 0; i < POOL; i++)
            shadow_link[i] = COUNT_W'(i + 1);
        shadow_head  = NO_ENTRY;
        shadow_free  = '0;
        shadow_count = '0;
    endfunction

    // Pop the free head and store the key there; caller checks for room.
    function automatic logic [COUNT_W-1:0] take_entry(logic signed [KEY_W-1:0] key);
        logic [COUNT_W-1:0] n;
        n = shadow_free;
        shadow_free  = shadow_link[n];
        shadow_key[n] = key;
        shadow_count++;
        return n;
    endfunction

    // Push a freed entry back onto the free head.
    function automatic void give_back(logic [COUNT_W-1:0] n);
        shadow_link[n] = shadow_free;
        shadow_free    = n;
        if (shadow_count != 0)
            shadow_count--;
    endfunction

    // Hook n after prev, or make it the head when prev is no entry.
    function automatic void hook_after(logic [COUNT_W-1:0] prev, logic [COUNT_W-1:0] n);
        if (is_entry(prev))
            shadow_link[prev] = n;
        else
            shadow_head = n;
    endfunction

    // First entry holding key, or no entry; prev gets its predecessor.
    function automatic logic [COUNT_W-1:0] find_entry(logic signed [KEY_W-1:0] key,
                                                      output logic [COUNT_W-1:0] prev);
        logic [COUNT_W-1:0] cur;
        prev = NO_ENTRY;
        cur  = shadow_head;
        for (int steps = 0; steps < POOL && is_entry(cur); steps++) begin
            if (shadow_key[cur] == key)
                break;
            prev = cur;
            cur  = shadow_link[cur];
        end
        return cur;
    endfunction

    // Apply one request to the shadow pool and return the status it yields.
    function automatic t_list_status apply_request(llte_pkg::t_op op,
                                                   logic signed [KEY_W-1:0] key);
        logic [COUNT_W-1:0] prev;
        logic [COUNT_W-1:0] cur;
        logic [COUNT_W-1:0] n;
        logic               was_full;
        logic               was_empty;
        t_list_status       st;
        was_full  = !is_entry(shadow_free);
        was_empty = !is_entry(shadow_head);
        st.ok     = 1'b0;
        case (op)
            llte_pkg::OP_INS_SORTED: if (!was_full) begin
                // stop at the first entry whose key is not smaller (signed)
                prev = NO_ENTRY;
                cur  = shadow_head;
                for (int steps = 0; steps < POOL && is_entry(cur) && shadow_key[cur] < key;
                     steps++) begin
                    prev = cur;
                    cur  = shadow_link[cur];
                end
                n = take_entry(key);
                shadow_link[n] = cur;
                hook_after(prev, n);
                st.ok = 1'b1;
            end
            llte_pkg::OP_INS_HEAD, llte_pkg::OP_INS_TAIL: if (!was_full) begin
                if (op == llte_pkg::OP_INS_HEAD || was_empty) begin
                    n = take_entry(key);
                    shadow_link[n] = shadow_head;
                    shadow_head    = n;
                end else begin
                    cur = shadow_head;
                    for (int steps = 0; steps < POOL && is_entry(shadow_link[cur]); steps++)
                        cur = shadow_link[cur];
                    n = take_entry(key);
                    shadow_link[n]   = NO_ENTRY;
                    shadow_link[cur] = n;
                end
                st.ok = 1'b1;
            end
            llte_pkg::OP_RM_HEAD: if (!was_empty) begin
                n = shadow_head;
                shadow_head = shadow_link[n];
                give_back(n);
                st.ok = 1'b1;
            end
            llte_pkg::OP_RM_TAIL: if (!was_empty) begin
                // a one-entry list has no predecessor: the list goes empty
                prev = NO_ENTRY;
                cur  = shadow_head;
                for (int steps = 0; steps < POOL && is_entry(shadow_link[cur]); steps++) begin
                    prev = cur;
                    cur  = shadow_link[cur];
                end
                hook_after(prev, NO_ENTRY);
                give_back(cur);
                st.ok = 1'b1;
            end
            llte_pkg::OP_RM_KEY: if (!was_empty) begin
                cur = find_entry(key, prev);
                if (is_entry(cur)) begin
                    hook_after(prev, shadow_link[cur]);
                    give_back(cur);
                    st.ok = 1'b1;
                end
            end
            llte_pkg::OP_SEARCH: if (!was_empty) begin
                cur   = find_entry(key, prev);
                st.ok = is_entry(cur);
            end
            default: begin
                relink_shadow();
                st.ok = 1'b1;
            end
        endcase
        st.count     = shadow_count;
        st.empty_res = !is_entry(shadow_head);
        st.full_res  = !is_entry(shadow_free);
        return st;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Idle cycles for one item: none during calm stretches, otherwise a random draw.
    function automatic int draw_idle(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
            calm = $urandom_range(10, 40);
        return $urandom_range(0, 12);
    endfunction

    // Mostly keys from a small pool so searches and removes hit.
    function automatic logic signed [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return key_pool[$urandom_range(0, 15)];
        else if (r < 8)
            return $urandom;
        else
            return key_pool[$urandom_range(0, 3)];
    endfunction

    function automatic void queue_req(llte_pkg::t_op op, logic signed [KEY_W-1:0] key,
                                      bit drain);
        t_req_item it;
        it.op    = op;
        it.key   = key;
        it.gap   = draw_idle(tx_calm);
        it.drain = drain;
        pending_reqs.push_back(it);
        n_built++;
    endfunction

    // Print one line per mismatch and count every one.
    task automatic report_mismatch(string what, int want, int got);
        n_errors++;
        $display("[%0t] result %0d: %s expected %0d, got %0d",
                 $realtime, n_checked, what, want, got);
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Hold every engine input at a known value from time zero.
    initial begin
        req_bus.valid = 1'b0;
        req_bus.op    = llte_pkg::OP_CLEAR;
        req_bus.key   = '0;
        rsp_bus.ready = 1'b0;
    end

    // ------------------------------------------------------------------
    // Driver: take items from the pending queue, wait out each gap (and for a drain
    // item, every result), then hold valid until the engine takes the item. Predict on acceptance.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
            req_bus.op    <= llte_pkg::OP_CLEAR;
            req_bus.key   <= '0;
            tx_holding    = 1'b0;
            tx_presenting = 1'b0;
            tx_wait       = 0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                expected_status.push_back(apply_request(tx_cur.op, tx_cur.key));
                n_accepted++;
                tx_presenting = 1'b0;
                tx_holding    = 1'b0;
            end
            if (!tx_presenting) begin
                if (!tx_holding && pending_reqs.size() != 0) begin
                    tx_cur     = pending_reqs.pop_front();
                    tx_holding = 1'b1;
                    tx_wait    = tx_cur.gap;
                end
                if (tx_holding) begin
                    if (tx_wait > 0)
                        tx_wait--;
                    else if (!(tx_cur.drain && expected_status.size() != 0))
                        tx_presenting = 1'b1;
                end
            end
            // a single update of valid per edge keeps back-to-back items glitch free
            req_bus.valid <= tx_presenting;
            if (tx_presenting) begin
                req_bus.op  <= tx_cur.op;
                req_bus.key <= tx_cur.key;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest expectation,
    // then stall ready for a random number of cycles.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (expected_status.size() == 0) begin
                    report_mismatch("unexpected result, pending count", 0, 1);
                end else begin
                    t_list_status want;
                    want = expected_status.pop_front();
                    if (rsp_bus.ok !== want.ok)
                        report_mismatch("ok", want.ok, rsp_bus.ok);
                    if (rsp_bus.count !== want.count)
                        report_mismatch("count", want.count, rsp_bus.count);
                    if (rsp_bus.empty_res !== want.empty_res)
                        report_mismatch("empty_res", want.empty_res, rsp_bus.empty_res);
                    if (rsp_bus.full_res !== want.full_res)
                        report_mismatch("full_res", want.full_res, rsp_bus.full_res);
                    if (!want.ok)
                        n_refused++;
                    if (want.full_res)
                        n_full_seen++;
                    if (want.empty_res)
                        n_empty_seen++;
                end
                n_checked++;
                rx_wait = draw_idle(rx_calm);
            end
            if (rx_wait > 0) begin
                rx_wait--;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int phase_len;
        int kind;
        int r;
        llte_pkg::t_op op;

        n_built = 0; n_accepted = 0; n_checked = 0; n_errors = 0;
        n_refused = 0; n_full_seen = 0; n_empty_seen = 0;
        tx_calm = 0; rx_calm = 0;
        relink_shadow();
        for (int i = 0; i < POOL; i++)
            shadow_key[i] = '0;

        // extremes first: pick_key draws them by index 0..3
        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7fff_ffff;
        key_pool[2] = '0;
        key_pool[3] = -32'sd1;
        for (int i = 4; i < 16; i++)
            key_pool[i] = (i < 10) ? $signed(32'($urandom_range(0, 40)) - 32'sd20) : $urandom;

        // Directed: empty list refusals, key extremes, duplicates, absent key,
        // one-entry tail removal, tail insert into an empty list, clear.
        queue_req(llte_pkg::OP_CLEAR,      '0,             1'b0);
        queue_req(llte_pkg::OP_SEARCH,     '0,             1'b0);
        queue_req(llte_pkg::OP_RM_HEAD,    '0,             1'b0);
        queue_req(llte_pkg::OP_RM_TAIL,    '0,             1'b0);
        queue_req(llte_pkg::OP_RM_KEY,     '0,             1'b0);
        queue_req(llte_pkg::OP_INS_SORTED, 32'sh7fff_ffff, 1'b0);
        queue_req(llte_pkg::OP_INS_SORTED, 32'sh8000_0000, 1'b0);
        queue_req(llte_pkg::OP_INS_SORTED, '0,             1'b0);
        queue_req(llte_pkg::OP_INS_SORTED, '0,             1'b0);
        queue_req(llte_pkg::OP_INS_HEAD,   -32'sd1,        1'b0);
        queue_req(llte_pkg::OP_INS_TAIL,   32'sh1234_5678, 1'b0);
        queue_req(llte_pkg::OP_SEARCH,     32'sh8000_0000, 1'b0);
        queue_req(llte_pkg::OP_SEARCH,     32'sd5,         1'b0);
        queue_req(llte_pkg::OP_RM_KEY,     32'sd5,         1'b0);
        queue_req(llte_pkg::OP_RM_KEY,     '0,             1'b0);
        queue_req(llte_pkg::OP_RM_HEAD,    '0,             1'b0);
        queue_req(llte_pkg::OP_RM_TAIL,    '0,             1'b0);
        queue_req(llte_pkg::OP_CLEAR,      '0,             1'b1);
        queue_req(llte_pkg::OP_INS_TAIL,   32'sd42,        1'b0);
        queue_req(llte_pkg::OP_RM_TAIL,    '0,             1'b0);
        queue_req(llte_pkg::OP_INS_HEAD,   32'shaaaa_5555, 1'b0);
        queue_req(llte_pkg::OP_SEARCH,     32'shaaaa_5555, 1'b0);
        queue_req(llte_pkg::OP_RM_KEY,     32'shaaaa_5555, 1'b0);
        queue_req(llte_pkg::OP_SEARCH,     32'shaaaa_5555, 1'b0);

        // Random: fill phases push the pool to full and past it, drain phases
        // empty it and keep removing, mixed phases stir everything.
        while (n_built < N_ITEMS) begin
            kind      = $urandom_range(0, 2);
            phase_len = (kind == 2) ? $urandom_range(20, 60) : $urandom_range(70, 90);
            for (int i = 0; i < phase_len && n_built < N_ITEMS; i++) begin
                r = $urandom_range(0, 99);
                case (kind)
                    0:       op = (r < 85) ? llte_pkg::t_op'($urandom_range(0, 2))
                                           : llte_pkg::t_op'($urandom_range(3, 6));
                    1:       op = (r < 85) ? llte_pkg::t_op'($urandom_range(3, 5))
                                           : ((r < 95) ? llte_pkg::OP_SEARCH
                                                       : llte_pkg::t_op'($urandom_range(0, 2)));
                    default: op = (r < 3) ? llte_pkg::OP_CLEAR
                                          : llte_pkg::t_op'($urandom_range(0, 6));
                endcase
                queue_req(op, pick_key(), (i == 0) && ($urandom_range(0, 2) == 0));
            end
        end

        // Hold here until every item is taken and answered, then let the
        // engine sit idle long enough for any stray result to show up.
        @(posedge i_clk);
        while (!(n_accepted == n_built && expected_status.size() == 0))
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests over every op, %0d refused; %0d results reported a full pool",
                 n_accepted, n_refused, n_full_seen);
        $display("and %0d an empty list, with random gaps and stalls on both channels.",
                 n_empty_seen);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Bound the run well beyond the slowest correct schedule.
    initial begin
        #(5_000_000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
